// ----- src/sttm_pkg.sv -----
`timescale 1ns / 1ps

package sttm_pkg;

    localparam int DEF_MAX_ENTRIES = 32;
    localparam int DEF_INDEX_BITS  = 4;
    localparam int DEF_VALUE_BITS  = 16;

    // request codes carried on s_tuser
    localparam logic [1:0] REQ_LOAD_A = 2'd0;
    localparam logic [1:0] REQ_LOAD_B = 2'd1;
    localparam logic [1:0] REQ_START  = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } sttm_status_t;

endpackage

// ----- src/sttm_ram.sv -----
`timescale 1ns / 1ps

module sttm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- src/sttm_merge.sv -----
`timescale 1ns / 1ps

module sttm_merge import sttm_pkg::*; #(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int INDEX_BITS  = DEF_INDEX_BITS,
    parameter int VALUE_BITS  = DEF_VALUE_BITS,
    localparam int CW    = $clog2(MAX_ENTRIES + 1),
    localparam int AW    = $clog2(MAX_ENTRIES),
    localparam int TW    = 2 * INDEX_BITS + VALUE_BITS,
    localparam int OW    = 2 * INDEX_BITS + VALUE_BITS + 1,
    localparam int OUT_W = ((OW + 7) / 8) * 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [CW-1:0]      count_a,
    input  logic [CW-1:0]      count_b,
    output sttm_status_t       status,
    output logic               re_a,
    output logic [AW-1:0]      raddr_a,
    input  logic [TW-1:0]      rdata_a,
    output logic               re_b,
    output logic [AW-1:0]      raddr_b,
    input  logic [TW-1:0]      rdata_b,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [OUT_W-1:0]   m_tdata,   // out_row, out_col, out_value
    output logic               m_tuser,   // out_valid
    output logic               m_tlast
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_CMP  = 2'd2;

    logic [1:0]              state_reg, state_next;
    logic [CW-1:0]           ptr_a_reg, ptr_a_next;
    logic [CW-1:0]           ptr_b_reg, ptr_b_next;
    logic                    vld_reg, vld_next;
    logic                    last_reg, last_next;
    logic                    flag_reg, flag_next;
    logic [OW-1:0]           word_reg, word_next;

    logic                    has_a, has_b, take_a, take_b, out_free, done;
    logic [INDEX_BITS-1:0]   a_row, a_col, b_row, b_col;
    logic [VALUE_BITS-1:0]   a_val, b_val;
    logic [VALUE_BITS:0]     sum;

    assign a_row = rdata_a[INDEX_BITS-1:0];
    assign a_col = rdata_a[2*INDEX_BITS-1:INDEX_BITS];
    assign a_val = rdata_a[TW-1:2*INDEX_BITS];
    assign b_row = rdata_b[INDEX_BITS-1:0];
    assign b_col = rdata_b[2*INDEX_BITS-1:INDEX_BITS];
    assign b_val = rdata_b[TW-1:2*INDEX_BITS];

    assign has_a    = ptr_a_reg < count_a;
    assign has_b    = ptr_b_reg < count_b;
    assign out_free = !vld_reg || m_tready;
    assign sum      = {a_val[VALUE_BITS-1], a_val} + {b_val[VALUE_BITS-1], b_val};

    always_comb
    begin
        if (has_a && has_b)
        begin
            take_a = {a_row, a_col} <= {b_row, b_col};
            take_b = {b_row, b_col} <= {a_row, a_col};
        end
        else
        begin
            take_a = has_a;
            take_b = !has_a;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ptr_a_next = ptr_a_reg;
        ptr_b_next = ptr_b_reg;
        vld_next   = vld_reg && !m_tready;
        last_next  = last_reg;
        flag_next  = flag_reg;
        word_next  = word_reg;
        re_a       = 1'b0;
        re_b       = 1'b0;
        done       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ptr_a_next = '0;
                    ptr_b_next = '0;
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                re_a       = has_a;
                re_b       = has_b;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (out_free)
                begin
                    vld_next = 1'b1;
                    if (!has_a && !has_b)
                    begin
                        // both lists empty: one blank word marked last
                        word_next = '0;
                        flag_next = 1'b0;
                    end
                    else
                    begin
                        flag_next  = 1'b1;
                        ptr_a_next = ptr_a_reg + CW'(take_a);
                        ptr_b_next = ptr_b_reg + CW'(take_b);
                        if (take_a && take_b)
                        begin
                            word_next = {sum, a_col, a_row};
                        end
                        else if (take_a)
                        begin
                            word_next = {a_val[VALUE_BITS-1], a_val, a_col, a_row};
                        end
                        else
                        begin
                            word_next = {b_val[VALUE_BITS-1], b_val, b_col, b_row};
                        end
                    end
                    if (ptr_a_next >= count_a && ptr_b_next >= count_b)
                    begin
                        last_next  = 1'b1;
                        done       = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        last_next  = 1'b0;
                        state_next = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ptr_a_reg <= '0;
            ptr_b_reg <= '0;
            vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_a_reg <= ptr_a_next;
            ptr_b_reg <= ptr_b_next;
            vld_reg   <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        flag_reg <= flag_next;
        word_reg <= word_next;
    end

    assign raddr_a     = ptr_a_reg[AW-1:0];
    assign raddr_b     = ptr_b_reg[AW-1:0];
    assign status.busy = state_reg != ST_IDLE;
    assign status.done = done;
    assign m_tvalid    = vld_reg;
    assign m_tdata     = OUT_W'(word_reg);
    assign m_tuser     = flag_reg;
    assign m_tlast     = last_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == ST_IDLE)
        else $error("start while merge busy");

    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (ptr_a_reg <= count_a && ptr_b_reg <= count_b))
        else $error("read pointer past list end");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> state_reg == ST_IDLE && m_tvalid && m_tlast)
        else $error("merge end not followed by last word");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP && vld_reg && !m_tready) |=> state_reg == ST_CMP)
        else $error("merge advanced over a stalled output");

endmodule

// ----- src/sparse_triplet_merge_add_top.sv -----
`timescale 1ns / 1ps

// Sparse triplet merge-add.
// Slave channel: s_tuser carries the request (load A, load B, start merge);
// s_tdata carries the triplet for loads (ignored on start). A load into a
// full list is dropped; loads are taken back to back. Request code 3 is ignored.
// Start merges the two lists in row-major order; matching positions give
// one word holding the sum. Words leave on the master channel, m_tuser set
// when the word holds an entry, m_tlast on the final word of the merge.
// Two empty lists give one blank word with m_tuser low and m_tlast high.
// After start is taken, each word needs a read of both list RAMs, then the
// compare and add, which registers the word; the next read follows only once
// that word has been registered.
// s_tready is low while a merge runs; it rises as the last word is
// registered, even while that word still waits on m_tready.
// A stalled receiver holds the merge at its compare step; nothing is lost.
// Reset empties both lists and the output; RAM contents are left as they are.
// Both lists are empty again once a merge ends.
module sparse_triplet_merge_add_top import sttm_pkg::*; #(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int INDEX_BITS  = DEF_INDEX_BITS,
    parameter int VALUE_BITS  = DEF_VALUE_BITS,
    localparam int CW    = $clog2(MAX_ENTRIES + 1),
    localparam int AW    = $clog2(MAX_ENTRIES),
    localparam int TW    = 2 * INDEX_BITS + VALUE_BITS,
    localparam int IN_W  = ((TW + 7) / 8) * 8,
    localparam int OUT_W = ((TW + 1 + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // entry_row, entry_col, entry_value
    input  logic [1:0]       s_tuser,   // req_type
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // out_row, out_col, out_value
    output logic             m_tuser,   // out_valid
    output logic             m_tlast
);

    logic [CW-1:0]   count_a_reg, count_a_next;
    logic [CW-1:0]   count_b_reg, count_b_next;
    sttm_status_t    status;
    logic            s_fire, we_a, we_b, start;
    logic            re_a, re_b;
    logic [AW-1:0]   raddr_a, raddr_b;
    logic [TW-1:0]   rdata_a, rdata_b;

    assign s_tready = !status.busy;
    assign s_fire   = s_tvalid && s_tready;
    assign we_a     = s_fire && s_tuser == REQ_LOAD_A && count_a_reg < CW'(MAX_ENTRIES);
    assign we_b     = s_fire && s_tuser == REQ_LOAD_B && count_b_reg < CW'(MAX_ENTRIES);
    assign start    = s_fire && s_tuser == REQ_START;

    always_comb
    begin
        count_a_next = count_a_reg;
        count_b_next = count_b_reg;
        if (status.done)
        begin
            count_a_next = '0;
            count_b_next = '0;
        end
        else
        begin
            if (we_a)
            begin
                count_a_next = count_a_reg + CW'(1);
            end
            if (we_b)
            begin
                count_b_next = count_b_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_a_reg <= '0;
            count_b_reg <= '0;
        end
        else
        begin
            count_a_reg <= count_a_next;
            count_b_reg <= count_b_next;
        end
    end

    sttm_ram #(
        .WIDTH (TW),
        .DEPTH (MAX_ENTRIES)
    ) u_ram_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (count_a_reg[AW-1:0]),
        .wdata (s_tdata[TW-1:0]),
        .re    (re_a),
        .raddr (raddr_a),
        .rdata (rdata_a)
    );

    sttm_ram #(
        .WIDTH (TW),
        .DEPTH (MAX_ENTRIES)
    ) u_ram_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (count_b_reg[AW-1:0]),
        .wdata (s_tdata[TW-1:0]),
        .re    (re_b),
        .raddr (raddr_b),
        .rdata (rdata_b)
    );

    sttm_merge #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .INDEX_BITS  (INDEX_BITS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .count_a  (count_a_reg),
        .count_b  (count_b_reg),
        .status   (status),
        .re_a     (re_a),
        .raddr_a  (raddr_a),
        .rdata_a  (rdata_a),
        .re_b     (re_b),
        .raddr_b  (raddr_b),
        .rdata_b  (rdata_b),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import sttm_pkg::*;

    localparam int IN_W        = ((2 * DEF_INDEX_BITS + DEF_VALUE_BITS + 7) / 8) * 8;
    localparam int OUT_W       = ((2 * DEF_INDEX_BITS + DEF_VALUE_BITS + 1 + 7) / 8) * 8;
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 400;
    localparam int MAX_SHOWN   = 10;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [DEF_INDEX_BITS-1:0] row;
        logic [DEF_INDEX_BITS-1:0] col;
        logic [DEF_VALUE_BITS-1:0] value;
    } triplet_t;

    typedef struct packed {
        logic [1:0] req;
        triplet_t   t;
    } request_t;

    typedef struct packed {
        logic [DEF_INDEX_BITS-1:0] row;
        logic [DEF_INDEX_BITS-1:0] col;
        logic [DEF_VALUE_BITS:0]   value;
        logic                      valid;
        logic                      last;
    } merged_word_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;   // entry_row, entry_col, entry_value
    logic [1:0]       s_tuser = REQ_LOAD_A;   // req_type
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;   // out_row, out_col, out_value
    logic             m_tuser;   // out_valid
    logic             m_tlast;

    // traffic state
    request_t     pending_requests[$];
    merged_word_t expected_words[$];
    triplet_t     list_a[$];
    triplet_t     list_b[$];
    request_t     drv_item;
    merged_word_t got_word;
    merged_word_t want_word;

    int unsigned send_idle_pct = 26;
    int unsigned recv_idle_pct = 59;
    logic        hold_arm = 1'b0;
    logic        hold_done;
    int unsigned hold_left;
    int unsigned stall_cycles = 0;

    int n_pushed = 0;
    int n_accepted = 0;
    int n_errors = 0;
    int n_merges = 0;
    int n_blank = 0;
    int n_dropped = 0;
    int n_sums = 0;
    int n_words = 0;

    always #5 clk = ~clk;

    sparse_triplet_merge_add_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // ---------------------------------------------------------------- predictor

    function automatic void merge_lists();
        merged_word_t words[$];
        merged_word_t w;
        logic [2*DEF_INDEX_BITS-1:0] key_a;
        logic [2*DEF_INDEX_BITS-1:0] key_b;
        int  ia;
        int  ib;
        bit  take_a;
        bit  take_b;
        ia = 0;
        ib = 0;
        while (ia < list_a.size() || ib < list_b.size())
        begin
            if (ia < list_a.size() && ib < list_b.size())
            begin
                key_a  = {list_a[ia].row, list_a[ia].col};
                key_b  = {list_b[ib].row, list_b[ib].col};
                take_a = (key_a <= key_b);
                take_b = (key_b <= key_a);
            end
            else
            begin
                take_a = (ia < list_a.size());
                take_b = !take_a;
            end
            w.valid = 1'b1;
            w.last  = 1'b0;
            if (take_a && take_b)
            begin
                w.row   = list_a[ia].row;
                w.col   = list_a[ia].col;
                w.value = {list_a[ia].value[DEF_VALUE_BITS-1], list_a[ia].value}
                        + {list_b[ib].value[DEF_VALUE_BITS-1], list_b[ib].value};
                ia++;
                ib++;
                n_sums++;
            end
            else if (take_a)
            begin
                w.row   = list_a[ia].row;
                w.col   = list_a[ia].col;
                w.value = {list_a[ia].value[DEF_VALUE_BITS-1], list_a[ia].value};
                ia++;
            end
            else
            begin
                w.row   = list_b[ib].row;
                w.col   = list_b[ib].col;
                w.value = {list_b[ib].value[DEF_VALUE_BITS-1], list_b[ib].value};
                ib++;
            end
            words.push_back(w);
        end
        if (words.size() == 0)
        begin
            w = '0;
            words.push_back(w);
            n_blank++;
        end
        words[words.size()-1].last = 1'b1;
        foreach (words[i])
            expected_words.push_back(words[i]);
        list_a.delete();
        list_b.delete();
        n_merges++;
    endfunction

    function automatic void apply_request(request_t rq);
        case (rq.req)
            REQ_LOAD_A:
                if (list_a.size() < DEF_MAX_ENTRIES)
                    list_a.push_back(rq.t);
                else
                    n_dropped++;
            REQ_LOAD_B:
                if (list_b.size() < DEF_MAX_ENTRIES)
                    list_b.push_back(rq.t);
                else
                    n_dropped++;
            REQ_START:
                merge_lists();
            default:
                ;
        endcase
    endfunction

    // ---------------------------------------------------------------- stimulus

    task automatic push_item(logic [1:0] req, int row, int col, logic [15:0] value);
        request_t rq;
        rq.req     = req;
        rq.t.row   = row[DEF_INDEX_BITS-1:0];
        rq.t.col   = col[DEF_INDEX_BITS-1:0];
        rq.t.value = value;
        pending_requests.push_back(rq);
        if (req != REQ_UNUSED)
            n_pushed++;
    endtask

    function automatic logic [15:0] pick_value();
        logic [15:0] v;
        case ($urandom_range(15))
            0:       v = 16'h8000;
            1:       v = 16'h7fff;
            2:       v = 16'h0000;
            3:       v = 16'hffff;
            default: v = 16'($urandom_range(65535));
        endcase
        return v;
    endfunction

    // one merge: loads for A and B interleaved, then start
    task automatic gen_sequence(input bit big);
        bit          used_a[256];
        bit          used_b[256];
        logic [15:0] val_a[256];
        int          keys_a[$];
        int          keys_b[$];
        int          na;
        int          nb;
        int          k;
        int          ia;
        int          ib;
        int          i;
        bit          sorted;
        bit          pick_a;
        logic [15:0] v;
        if (big || $urandom_range(99) < 6)
        begin
            na = $urandom_range(28, 34);
            nb = $urandom_range(28, 34);
        end
        else
        begin
            na = $urandom_range(0, 6);
            nb = $urandom_range(0, 6);
        end
        sorted = big || ($urandom_range(99) < 80);
        for (i = 0; i < 256; i++)
        begin
            used_a[i] = 1'b0;
            used_b[i] = 1'b0;
            val_a[i]  = pick_value();
        end
        if (sorted)
        begin
            while (keys_a.size() < na)
            begin
                k = $urandom_range(255);
                if (!used_a[k])
                begin
                    used_a[k] = 1'b1;
                    keys_a.push_back(k);
                end
            end
            // about half of B lands on positions already in A
            while (keys_b.size() < nb)
            begin
                if (na > 0 && $urandom_range(1))
                    k = keys_a[$urandom_range(na - 1)];
                else
                    k = $urandom_range(255);
                if (!used_b[k])
                begin
                    used_b[k] = 1'b1;
                    keys_b.push_back(k);
                end
            end
            keys_a.sort();
            keys_b.sort();
        end
        else
        begin
            // out of order, with repeated positions now and then
            for (i = 0; i < na; i++)
                keys_a.push_back((i > 0 && $urandom_range(3) == 0) ? keys_a[i-1]
                                                                  : $urandom_range(255));
            for (i = 0; i < nb; i++)
                keys_b.push_back((i > 0 && $urandom_range(3) == 0) ? keys_b[i-1]
                                                                  : $urandom_range(255));
        end
        ia = 0;
        ib = 0;
        while (ia < na || ib < nb)
        begin
            if ($urandom_range(24) == 0)
                push_item(REQ_UNUSED, $urandom_range(15), $urandom_range(15), pick_value());
            pick_a = (ib >= nb) || (ia < na && $urandom_range(1));
            if (pick_a)
            begin
                k = keys_a[ia];
                push_item(REQ_LOAD_A, k / 16, k % 16, val_a[k]);
                ia++;
            end
            else
            begin
                k = keys_b[ib];
                if (used_a[k] && $urandom_range(3) == 0)
                    v = -val_a[k];
                else
                    v = pick_value();
                push_item(REQ_LOAD_B, k / 16, k % 16, v);
                ib++;
            end
        end
        push_item(REQ_START, $urandom_range(15), $urandom_range(15), pick_value());
    endtask

    task automatic gen_random(input int target);
        int first;
        first = n_pushed;
        while (n_pushed - first < target)
            gen_sequence(1'b0);
    endtask

    task automatic wait_drained();
        while (n_accepted != n_pushed + 0 || pending_requests.size() != 0
               || expected_words.size() != 0)
            @(negedge clk);
    endtask

    // ---------------------------------------------------------------- driver

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= REQ_LOAD_A;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                apply_request(drv_item);
                if (drv_item.req != REQ_UNUSED)
                    n_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    drv_item = pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {drv_item.t.value, drv_item.t.col, drv_item.t.row};
                    s_tuser  <= drv_item.req;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    task automatic report_error(string what);
        n_errors++;
        if (n_errors <= MAX_SHOWN)
            $display("%0t: %s", $realtime, what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                n_words++;
                got_word.row   = m_tdata[DEF_INDEX_BITS-1:0];
                got_word.col   = m_tdata[2*DEF_INDEX_BITS-1:DEF_INDEX_BITS];
                got_word.value = m_tdata[2*DEF_INDEX_BITS+DEF_VALUE_BITS:2*DEF_INDEX_BITS];
                got_word.valid = m_tuser;
                got_word.last  = m_tlast;
                if (expected_words.size() == 0)
                    report_error($sformatf("unexpected word row=%0d col=%0d value=%h valid=%b last=%b",
                                           got_word.row, got_word.col, got_word.value,
                                           got_word.valid, got_word.last));
                else
                begin
                    want_word = expected_words.pop_front();
                    if (got_word != want_word)
                        report_error($sformatf({"word mismatch: exp row=%0d col=%0d value=%h ",
                                                "valid=%b last=%b, got row=%0d col=%0d value=%h ",
                                                "valid=%b last=%b"},
                                               want_word.row, want_word.col, want_word.value,
                                               want_word.valid, want_word.last,
                                               got_word.row, got_word.col, got_word.value,
                                               got_word.valid, got_word.last));
                end
            end
            // the long hold lets the merge back up into the input side
            if (hold_arm && !hold_done)
            begin
                hold_done <= 1'b1;
                hold_left <= LONG_HOLD;
                m_tready  <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ---------------------------------------------------------------- watchdog

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $realtime, STALL_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty merge
        push_item(REQ_START, 0, 0, 16'h0000);
        // extremes of position and value, summed on both corners
        push_item(REQ_LOAD_A, 0, 0, 16'h8000);
        push_item(REQ_LOAD_B, 0, 0, 16'h8000);
        push_item(REQ_LOAD_A, 15, 15, 16'h7fff);
        push_item(REQ_LOAD_B, 15, 15, 16'h7fff);
        push_item(REQ_START, 15, 15, 16'hffff);
        // A alone
        push_item(REQ_LOAD_A, 3, 4, 16'h0001);
        push_item(REQ_LOAD_A, 7, 0, 16'hffff);
        push_item(REQ_START, 0, 0, 16'h0000);
        // B alone
        push_item(REQ_LOAD_B, 0, 15, 16'h1234);
        push_item(REQ_LOAD_B, 15, 0, 16'hedcb);
        push_item(REQ_START, 0, 0, 16'h0000);
        // zero sum kept; unused code in between
        push_item(REQ_LOAD_A, 5, 5, 16'd100);
        push_item(REQ_LOAD_B, 5, 5, -16'sd100);
        push_item(REQ_UNUSED, 10, 5, 16'ha5a5);
        push_item(REQ_LOAD_B, 5, 6, 16'h0001);
        push_item(REQ_START, 0, 0, 16'h0000);
        // out of order in A, repeated position in B
        push_item(REQ_LOAD_A, 9, 9, 16'h0001);
        push_item(REQ_LOAD_A, 2, 2, 16'h0002);
        push_item(REQ_LOAD_B, 5, 5, 16'h0003);
        push_item(REQ_LOAD_B, 5, 5, 16'h0004);
        push_item(REQ_START, 0, 0, 16'h0000);

        gen_random(95);
        wait_drained();

        send_idle_pct <= 59;
        recv_idle_pct <= 26;
        gen_random(95);
        wait_drained();

        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        hold_arm      <= 1'b1;
        gen_sequence(1'b1);
        gen_random(70);
        wait_drained();

        repeat (20) @(negedge clk);
        if (expected_words.size() != 0)
            report_error($sformatf("%0d words never arrived", expected_words.size()));
        $display("Covered %0d requests, %0d merges (%0d empty), %0d words, %0d paired sums,",
                 n_accepted, n_merges, n_blank, n_words, n_sums);
        $display("%0d loads dropped on full lists, %0d errors", n_dropped, n_errors);
        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
